// ===== rtl/iqs_pkg.sv =====
// ----------------------------------------------------------------------------
// iqs_pkg
// Shared types and constants of the integer quicksort engine: value type and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package iqs_pkg;

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // controller to datapath
  typedef struct packed {
    logic load_en;      // input request accepted
    logic clr_set;      // set finished, clear count and drop flag
    logic push_init;    // push the whole range
    logic pop;          // pop one range, stack read issued
    logic take_bounds;  // latch popped bounds, read the middle element
    logic take_pivot;   // latch pivot, read at left scan
    logic lscan_step;   // advance left scan
    logic lscan_exit;   // keep left element, read at right scan
    logic rscan_step;   // retreat right scan
    logic swap_first;   // write right element at left scan
    logic swap_second;  // write left element at right scan, move both scans
    logic push_hi;      // push upper side if it holds more than one element
    logic push_lo;      // push lower side if it holds more than one element
    logic emit_start;   // clear emit index
    logic emit_read;    // read at emit index
    logic emit_load;    // load output register, advance emit index
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_lt2;
    logic sp_zero;
    logic lscan_go;
    logic rscan_go;
    logic cross_ok;
    logic swap_cont;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/iqs_in_if.sv =====
// ----------------------------------------------------------------------------
// iqs_in_if
// Input channel: one value per request, with a marker on the final one.
// ----------------------------------------------------------------------------
interface iqs_in_if;
  logic            valid;
  logic            ready;
  iqs_pkg::value_t value;
  logic            last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

// ===== rtl/iqs_out_if.sv =====
// ----------------------------------------------------------------------------
// iqs_out_if
// Result channel: sorted values in ascending order with end and drop flags.
// ----------------------------------------------------------------------------
interface iqs_out_if;
  logic            valid;
  logic            ready;
  iqs_pkg::value_t sorted_value;
  logic            last_result;
  logic            overflow;

  modport source (output valid, output sorted_value, output last_result,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input last_result,
                  input overflow, output ready);
endinterface

// ===== rtl/iqs_datapath.sv =====
// ----------------------------------------------------------------------------
// iqs_datapath
// Element store, bounds stack, scan indices, pivot and output register of the
// quicksort engine. Steps are chosen by the controller command bundle.
// ----------------------------------------------------------------------------
module iqs_datapath #(
  parameter int MAX_ITEMS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  iqs_pkg::cmd_t   cmd,
  output iqs_pkg::sts_t   sts,
  input  iqs_pkg::value_t in_value,
  input  logic            out_ready,
  output logic            out_valid,
  output iqs_pkg::value_t out_sorted_value,
  output logic            out_last_result,
  output logic            out_overflow
);

  localparam int IDX_W  = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int SCAN_W = IDX_W + 2;
  localparam int BND_W  = 2 * IDX_W;

  typedef logic signed [SCAN_W-1:0] scan_t;

  // storage
  iqs_pkg::value_t   mem [MAX_ITEMS];
  logic [BND_W-1:0]  stk [MAX_ITEMS];

  logic [CNT_W-1:0]  cnt_r;
  logic              dropped_r;
  logic [CNT_W-1:0]  sp_r;
  logic [CNT_W-1:0]  k_r;
  logic [IDX_W-1:0]  lo_r;
  logic [IDX_W-1:0]  hi_r;
  scan_t             left_r;
  scan_t             right_r;
  iqs_pkg::value_t   pivot_r;
  iqs_pkg::value_t   tmpl_r;
  iqs_pkg::value_t   rd_r;
  logic [BND_W-1:0]  stk_rd_r;

  logic              out_valid_r;
  iqs_pkg::value_t   out_value_r;
  logic              out_last_r;
  logic              out_ovf_r;

  logic              cnt_lt_max;
  logic              sp_lt_max;
  logic [IDX_W-1:0]  stk_lo;
  logic [IDX_W-1:0]  stk_hi;
  scan_t             lo_s;
  scan_t             hi_s;
  logic [IDX_W:0]    mid_sum;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  iqs_pkg::value_t   mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic              stk_we;
  logic [IDX_W-1:0]  stk_waddr;
  logic [BND_W-1:0]  stk_wdata;
  logic [IDX_W-1:0]  stk_raddr;
  logic              emit_last;

  assign cnt_lt_max = cnt_r < CNT_W'(MAX_ITEMS);
  assign sp_lt_max  = sp_r < CNT_W'(MAX_ITEMS);
  assign stk_lo     = stk_rd_r[BND_W-1:IDX_W];
  assign stk_hi     = stk_rd_r[IDX_W-1:0];
  assign lo_s       = scan_t'({2'b00, lo_r});
  assign hi_s       = scan_t'({2'b00, hi_r});
  assign mid_sum    = {1'b0, stk_lo} + {1'b0, stk_hi};
  assign stk_raddr  = IDX_W'(sp_r - CNT_W'(1));
  assign emit_last  = (k_r + CNT_W'(1)) == cnt_r;

  // element store write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r[IDX_W-1:0];
    mem_wdata = in_value;
    priority if (cmd.load_en) begin
      mem_we = cnt_lt_max;
    end else if (cmd.swap_first) begin
      mem_we    = 1'b1;
      mem_waddr = left_r[IDX_W-1:0];
      mem_wdata = rd_r;
    end else if (cmd.swap_second) begin
      mem_we    = 1'b1;
      mem_waddr = right_r[IDX_W-1:0];
      mem_wdata = tmpl_r;
    end else begin
      mem_we = 1'b0;
    end
  end

  // element store read address
  always_comb begin
    mem_raddr = left_r[IDX_W-1:0];
    priority if (cmd.take_bounds) begin
      mem_raddr = mid_sum[IDX_W:1];
    end else if (cmd.lscan_step || cmd.swap_second) begin
      mem_raddr = IDX_W'(left_r + scan_t'(1));
    end else if (cmd.lscan_exit) begin
      mem_raddr = right_r[IDX_W-1:0];
    end else if (cmd.rscan_step) begin
      mem_raddr = IDX_W'(right_r - scan_t'(1));
    end else if (cmd.emit_read) begin
      mem_raddr = k_r[IDX_W-1:0];
    end else begin
      mem_raddr = left_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= mem[mem_raddr];
  end

  // bounds stack write port
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = sp_r[IDX_W-1:0];
    stk_wdata = {lo_r, hi_r};
    priority if (cmd.push_init) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = {IDX_W'(0), IDX_W'(cnt_r - CNT_W'(1))};
    end else if (cmd.push_hi) begin
      stk_we    = (hi_s > left_r) && sp_lt_max;
      stk_wdata = {left_r[IDX_W-1:0], hi_r};
    end else if (cmd.push_lo) begin
      stk_we    = (lo_s < right_r) && sp_lt_max;
      stk_wdata = {lo_r, right_r[IDX_W-1:0]};
    end else begin
      stk_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[stk_waddr] <= stk_wdata;
    end
    stk_rd_r <= stk[stk_raddr];
  end

  // set count, drop flag and stack pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      dropped_r <= 1'b0;
      sp_r      <= '0;
    end else begin
      if (cmd.clr_set) begin
        cnt_r     <= '0;
        dropped_r <= 1'b0;
      end else if (cmd.load_en) begin
        if (cnt_lt_max) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end else begin
          dropped_r <= 1'b1;
        end
      end
      if (cmd.push_init) begin
        sp_r <= CNT_W'(1);
      end else if (cmd.pop) begin
        sp_r <= sp_r - CNT_W'(1);
      end else if (stk_we) begin
        sp_r <= sp_r + CNT_W'(1);
      end
    end
  end

  // partition work registers
  always_ff @(posedge clk) begin
    if (cmd.take_bounds) begin
      lo_r    <= stk_lo;
      hi_r    <= stk_hi;
      left_r  <= scan_t'({2'b00, stk_lo});
      right_r <= scan_t'({2'b00, stk_hi});
    end else begin
      if (cmd.lscan_step || cmd.swap_second) begin
        left_r <= left_r + scan_t'(1);
      end
      if (cmd.rscan_step || cmd.swap_second) begin
        right_r <= right_r - scan_t'(1);
      end
    end
    if (cmd.take_pivot) begin
      pivot_r <= rd_r;
    end
    if (cmd.lscan_exit) begin
      tmpl_r <= rd_r;
    end
    if (cmd.emit_start) begin
      k_r <= '0;
    end else if (cmd.emit_load) begin
      k_r <= k_r + CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_value_r <= rd_r;
      out_last_r  <= emit_last;
      out_ovf_r   <= dropped_r;
    end
  end

  // status back to the controller
  assign sts.cnt_lt2   = cnt_r < CNT_W'(2);
  assign sts.sp_zero   = sp_r == '0;
  assign sts.lscan_go  = (rd_r < pivot_r) && (left_r < hi_s);
  assign sts.rscan_go  = (pivot_r < rd_r) && (right_r > lo_s);
  assign sts.cross_ok  = left_r <= right_r;
  assign sts.swap_cont = (left_r + scan_t'(2)) <= right_r;
  assign sts.emit_last = emit_last;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_result  = out_last_r;
  assign out_overflow     = out_ovf_r;

endmodule

// ===== rtl/iqs_controller.sv =====
// ----------------------------------------------------------------------------
// iqs_controller
// Sequencer of the quicksort engine: load, partition passes driven from the
// bounds stack, then emission of the sorted set.
// ----------------------------------------------------------------------------
module iqs_controller (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last_item,
  output logic          in_ready,
  input  iqs_pkg::sts_t sts,
  output iqs_pkg::cmd_t cmd
);

  typedef enum logic [11:0] {
    S_LOAD      = 12'b0000_0000_0001,
    S_SORT_INIT = 12'b0000_0000_0010,
    S_POP       = 12'b0000_0000_0100,
    S_POP_WAIT  = 12'b0000_0000_1000,
    S_PIV_WAIT  = 12'b0000_0001_0000,
    S_LSCAN     = 12'b0000_0010_0000,
    S_RSCAN     = 12'b0000_0100_0000,
    S_SWAP2     = 12'b0000_1000_0000,
    S_PUSH_HI   = 12'b0001_0000_0000,
    S_PUSH_LO   = 12'b0010_0000_0000,
    S_EMIT_RD   = 12'b0100_0000_0000,
    S_EMIT_WAIT = 12'b1000_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_en = 1'b1;
          if (in_last_item) begin
            state_nxt = S_SORT_INIT;
          end
        end
      end
      S_SORT_INIT: begin
        if (sts.cnt_lt2) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_EMIT_RD;
        end else begin
          cmd.push_init = 1'b1;
          state_nxt     = S_POP;
        end
      end
      S_POP: begin
        if (sts.sp_zero) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_EMIT_RD;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cmd.take_bounds = 1'b1;
        state_nxt       = S_PIV_WAIT;
      end
      S_PIV_WAIT: begin
        cmd.take_pivot = 1'b1;
        state_nxt      = S_LSCAN;
      end
      S_LSCAN: begin
        if (sts.lscan_go) begin
          cmd.lscan_step = 1'b1;
        end else begin
          cmd.lscan_exit = 1'b1;
          state_nxt      = S_RSCAN;
        end
      end
      S_RSCAN: begin
        if (sts.rscan_go) begin
          cmd.rscan_step = 1'b1;
        end else if (sts.cross_ok) begin
          cmd.swap_first = 1'b1;
          state_nxt      = S_SWAP2;
        end else begin
          state_nxt = S_PUSH_HI;
        end
      end
      S_SWAP2: begin
        cmd.swap_second = 1'b1;
        state_nxt       = sts.swap_cont ? S_LSCAN : S_PUSH_HI;
      end
      S_PUSH_HI: begin
        cmd.push_hi = 1'b1;
        state_nxt   = S_PUSH_LO;
      end
      S_PUSH_LO: begin
        cmd.push_lo = 1'b1;
        state_nxt   = S_POP;
      end
      S_EMIT_RD: begin
        cmd.emit_read = 1'b1;
        state_nxt     = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        cmd.emit_read = 1'b1;
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) begin
            cmd.clr_set = 1'b1;
            state_nxt   = S_LOAD;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/integer_quicksort_engine.sv =====
// Loading accepts one request per cycle; a request marked last starts the sort.
// Sorting: each partition pops its bounds, reads the middle element as pivot, runs the
// left and right scans with a swap while they have not crossed, then pushes both sides
// (single store read port). Emission: each result is read from the store, then loaded
// once the output register is free; a set of fewer than two values skips the sort. One set is worked on at a time.
// Synchronous active-low reset clears the sequencer, counters and output valid.
// ----------------------------------------------------------------------------
// integer_quicksort_engine
// Collects signed values, sorts them by quicksort with a middle pivot and an
// explicit bounds stack, then streams them out in ascending order.
// ----------------------------------------------------------------------------
module integer_quicksort_engine #(
  parameter int MAX_ITEMS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  iqs_in_if.sink    in_chan,
  iqs_out_if.source out_chan
);

  iqs_pkg::cmd_t cmd;
  iqs_pkg::sts_t sts;

  // sequencer
  iqs_controller u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_last_item (in_chan.last_item),
    .in_ready     (in_chan.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // storage and arithmetic
  iqs_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_value         (in_chan.value),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_sorted_value (out_chan.sorted_value),
    .out_last_result  (out_chan.last_result),
    .out_overflow     (out_chan.overflow)
  );

endmodule

// ===== tb/tb_integer_quicksort_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_quicksort_engine
// Self-checking bench for the quicksort engine. Sets of signed values are
// streamed in with bursty valid and random stalls on the result side. Every
// set is sorted by a local middle-pivot partition sort and each result is
// compared field by field, including overflow on sets that exceed capacity.
// ----------------------------------------------------------------------------
module tb_integer_quicksort_engine;

  typedef iqs_pkg::value_t value_t;

  localparam int     CAP        = 64;
  localparam int     RAND_ITEMS = 470;
  localparam value_t VAL_MIN    = 32'sh8000_0000;
  localparam value_t VAL_MAX    = 32'sh7FFF_FFFF;

  typedef struct packed {
    value_t value;
    logic   last;
    logic   ovf;
  } sorted_res_t;

  // directed row: typed rows are single-value sets with an obvious answer
  typedef struct packed {
    value_t value;
    logic   last;
    bit     typed;
    value_t exp_value;
  } stim_row_t;

  localparam int N_DIRECTED = 25;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{VAL_MAX,        1'b1, 1'b1, VAL_MAX},
    '{VAL_MIN,        1'b1, 1'b1, VAL_MIN},
    '{32'sd0,         1'b1, 1'b1, 32'sd0},
    '{-32'sd1,        1'b1, 1'b1, -32'sd1},
    '{VAL_MAX,        1'b0, 1'b0, 32'sd0},
    '{VAL_MIN,        1'b1, 1'b0, 32'sd0},
    '{32'sd1,         1'b0, 1'b0, 32'sd0},
    '{-32'sd1,        1'b0, 1'b0, 32'sd0},
    '{32'sd0,         1'b1, 1'b0, 32'sd0},
    '{32'sd5,         1'b0, 1'b0, 32'sd0},
    '{32'sd5,         1'b0, 1'b0, 32'sd0},
    '{32'sd5,         1'b0, 1'b0, 32'sd0},
    '{32'sd5,         1'b1, 1'b0, 32'sd0},
    '{32'sh4000_0000, 1'b0, 1'b0, 32'sd0},
    '{32'shC000_0000, 1'b0, 1'b0, 32'sd0},
    '{32'sh7FFF_FFFE, 1'b0, 1'b0, 32'sd0},
    '{32'sh8000_0001, 1'b0, 1'b0, 32'sd0},
    '{32'sh5555_5555, 1'b1, 1'b0, 32'sd0},
    '{32'sd6,         1'b0, 1'b0, 32'sd0},
    '{32'sd5,         1'b0, 1'b0, 32'sd0},
    '{32'sd4,         1'b0, 1'b0, 32'sd0},
    '{32'sd3,         1'b0, 1'b0, 32'sd0},
    '{32'sd2,         1'b0, 1'b0, 32'sd0},
    '{32'sd1,         1'b1, 1'b0, 32'sd0},
    '{32'shAAAA_AAAA, 1'b1, 1'b1, 32'shAAAA_AAAA}
  };

  logic clk;
  logic rst_n;

  iqs_in_if  in_if ();
  iqs_out_if out_if ();

  integer_quicksort_engine #(.MAX_ITEMS(CAP)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // local copy of the set being collected
  value_t      held_vals [CAP];
  int          held_count;
  logic        held_dropped;
  sorted_res_t sorted_expect [$];

  int errors;
  int stored_items;
  int dropped_items;
  int sets_closed;
  int overflow_sets;
  int results_checked;
  int burst_left;

  // receiver stall state
  int       stall_mode;
  int       stall_count;
  bit [7:0] stall_pat;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // middle-pivot partition sort over the first n held values
  function automatic void sort_held(int n);
    int     lo_stk [CAP];
    int     hi_stk [CAP];
    int     sp;
    int     lo;
    int     hi;
    int     l;
    int     r;
    value_t piv;
    value_t t;
    if (n < 2) return;
    lo_stk[0] = 0;
    hi_stk[0] = n - 1;
    sp = 1;
    while (sp > 0) begin
      sp--;
      lo  = lo_stk[sp];
      hi  = hi_stk[sp];
      l   = lo;
      r   = hi;
      piv = held_vals[(lo + hi) / 2];
      do begin
        while (held_vals[l] < piv && l < hi) l++;
        while (piv < held_vals[r] && r > lo) r--;
        if (l <= r) begin
          t            = held_vals[l];
          held_vals[l] = held_vals[r];
          held_vals[r] = t;
          l++;
          r--;
        end
      end while (l <= r);
      // upper side first so the lower side is popped next
      if (hi > l && sp < CAP) begin
        lo_stk[sp] = l;
        hi_stk[sp] = hi;
        sp++;
      end
      if (lo < r && sp < CAP) begin
        lo_stk[sp] = lo;
        hi_stk[sp] = r;
        sp++;
      end
    end
  endfunction

  // update the set for one accepted request, queue results on the last one
  function automatic void predict_request(value_t v, logic last);
    sorted_res_t res;
    if (held_count < CAP) begin
      held_vals[held_count] = v;
      held_count++;
      stored_items++;
    end else begin
      held_dropped = 1'b1;
      dropped_items++;
    end
    if (last) begin
      sort_held(held_count);
      for (int k = 0; k < held_count; k++) begin
        res.value = held_vals[k];
        res.last  = (k == held_count - 1);
        res.ovf   = held_dropped;
        sorted_expect.push_back(res);
      end
      if (held_dropped) overflow_sets++;
      sets_closed++;
      held_count   = 0;
      held_dropped = 1'b0;
    end
  endfunction

  // drive one request in bursts with random gaps between them
  task automatic send_request(value_t v, logic last, bit typed, value_t exp_value);
    sorted_res_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 30)) @(posedge clk);
        else repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    in_if.valid     <= 1'b1;
    in_if.value     <= v;
    in_if.last_item <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
    predict_request(v, last);
    // the typed answer stands in for the computed one
    if (typed) begin
      void'(sorted_expect.pop_back());
      res.value = exp_value;
      res.last  = 1'b1;
      res.ovf   = 1'b0;
      sorted_expect.push_back(res);
    end
  endtask

  // hold off the sender until every queued result has come out
  task automatic drain_results(int settle);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sorted_expect.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic value_t pick_value(int mode);
    value_t picks [7];
    picks = '{VAL_MIN, VAL_MAX, 32'sd0, -32'sd1, 32'sd1, VAL_MIN + 1, VAL_MAX - 1};
    case (mode)
      0:       return value_t'($urandom);
      1:       return value_t'($urandom_range(0, 16)) - 32'sd8;
      default: return picks[$urandom_range(0, 6)];
    endcase
  endfunction

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    sorted_res_t exp_res;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (sorted_expect.size() == 0) begin
          $display("%0t: unexpected result value %0d last %0b ovf %0b", $time,
                   out_if.sorted_value, out_if.last_result, out_if.overflow);
          errors++;
        end else begin
          exp_res = sorted_expect.pop_front();
          results_checked++;
          if (out_if.sorted_value !== exp_res.value || out_if.last_result !== exp_res.last ||
              out_if.overflow !== exp_res.ovf) begin
            $display("%0t: mismatch expected value %0d last %0b ovf %0b, %s %0d last %0b ovf %0b",
                     $time, exp_res.value, exp_res.last, exp_res.ovf, "got value",
                     out_if.sorted_value, out_if.last_result, out_if.overflow);
            errors++;
          end
        end
      end
      // change stall mode every so often
      stall_count++;
      if (stall_count >= 150) begin
        stall_count = 0;
        stall_mode  = $urandom_range(0, 3);
        stall_pat   = 8'($urandom);
      end
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        2:       out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= stall_pat[stall_count[2:0]] | (stall_pat == '0);
      endcase
    end
  end

  // stimulus
  initial begin
    int     set_idx;
    int     set_size;
    int     val_mode;
    int     order_mode;
    value_t base;
    value_t v;

    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.value     <= '0;
    in_if.last_item <= 1'b0;
    held_count      = 0;
    held_dropped    = 1'b0;
    errors          = 0;
    stored_items    = 0;
    dropped_items   = 0;
    sets_closed     = 0;
    overflow_sets   = 0;
    results_checked = 0;
    burst_left      = 0;
    stall_mode      = 0;
    stall_count     = 0;
    stall_pat       = 8'hB2;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i])
      send_request(directed_rows[i].value, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].exp_value);

    drain_results(20);

    // random sets: a full store, a dropped last request and a long overflow
    set_idx = 0;
    while (stored_items < N_DIRECTED + RAND_ITEMS) begin
      if (set_idx == 3)                    set_size = CAP;
      else if (set_idx == 10)              set_size = CAP + 1;
      else if (set_idx == 20)              set_size = CAP + 6;
      else if ($urandom_range(0, 99) < 2)  set_size = $urandom_range(CAP - 2, CAP + 4);
      else if ($urandom_range(0, 1) == 0)  set_size = $urandom_range(1, 4);
      else                                 set_size = $urandom_range(5, 16);
      val_mode   = $urandom_range(0, 5) < 3 ? 0 : $urandom_range(1, 2);
      order_mode = $urandom_range(0, 7);
      base       = pick_value(val_mode);
      for (int k = 0; k < set_size; k++) begin
        case (order_mode)
          0:       v = base + value_t'(k);
          1:       v = base - value_t'(k);
          2:       v = base;
          default: v = pick_value(val_mode);
        endcase
        send_request(v, k == set_size - 1, 1'b0, '0);
      end
      if ($urandom_range(0, 11) == 0) drain_results($urandom_range(1, 10));
      set_idx++;
    end

    drain_results(300);

    $display("%0d sets with %0d values stored and %0d dropped, %0d sets overflowed",
             sets_closed, stored_items, dropped_items, overflow_sets);
    $display("%0d sorted results checked under random stalls", results_checked);
    if (errors == 0 && sorted_expect.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/iqs_pkg.sv
rtl/iqs_in_if.sv
rtl/iqs_out_if.sv
rtl/iqs_datapath.sv
rtl/iqs_controller.sv
rtl/integer_quicksort_engine.sv
tb/tb_integer_quicksort_engine.sv
